// File: sv/mono_bitmap_span_extractor_macros.svh
// Assertion helpers shared by the span extractor modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MONO_BITMAP_SPAN_EXTRACTOR_MACROS_SVH
`define MONO_BITMAP_SPAN_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MBSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbse: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MBSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbse: next-cycle check failed");

`endif

// File: sv/mbse_pkg.sv
`timescale 1ns / 1ps

package mbse_pkg;

    localparam int MAX_TILES_DEFAULT = 4;
    localparam int QUEUE_DEPTH       = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH    = 3'd4;

    localparam logic [8:0] RST_FRAME_WIDTH    = 9'd64;
    localparam logic [6:0] RST_FRAME_HEIGHT   = 7'd32;
    localparam logic [8:0] RST_DISPLAY_WIDTH  = 9'd64;
    localparam logic [6:0] RST_DISPLAY_HEIGHT = 7'd32;
    localparam logic [8:0] RST_PANEL_WIDTH    = 9'd0;

    localparam logic [8:0] MAX_FRAME_WIDTH  = 9'd256;
    localparam logic [6:0] MAX_FRAME_HEIGHT = 7'd64;

    typedef struct packed {
        logic [8:0] frame_width;
        logic [6:0] frame_height;
        logic [8:0] display_width;
        logic [6:0] display_height;
        logic [8:0] panel_width;
    } cfg_t;

    // One closed span as queued between front and back. In tile mode x holds
    // the offset inside a tile; the back adds each tile origin.
    typedef struct packed {
        logic [8:0] x;
        logic [5:0] y;
        logic [8:0] len;
        logic       tile;
    } span_entry_t;

endpackage

// File: sv/mono_bitmap_span_extractor.sv
`timescale 1ns / 1ps

// Monochrome bitmap span extractor.
// Pixel channel: pixel_valid / pixel_stall / pixel_lit, one pixel per request in
//   raster order; the block keeps its own column and row counters.
// Span channel: span_valid / span_stall with span_x, span_y, span_length and
//   last_span; last_span marks the final span produced by one pixel.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no pixel is in flight.
// Throughput: one pixel per cycle while pixel_stall is low. A span in tile
//   mode leaves as up to MAX_TILES requests, one per cycle while span_stall
//   is low, drained from a four-entry span queue; pixel_stall rises during a
//   config write, during the rebuild after it, and when that queue fills.
// A span closed by the front passes through the queue and the back's output
//   register before it appears on the span channel.
// After every config write the front rebuilds its segment position by walking
//   from column zero to the current column, with pixel_stall held high.
// Reset clears the position counters, any open run and the queue, and loads
//   the config defaults (64 x 32 frame on a 64 x 32 display, no panels).
// A stalled span holds its fields; the queue absorbs spans behind it.

module mono_bitmap_span_extractor
#(
    parameter int MAX_TILES = mbse_pkg::MAX_TILES_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic                           pixel_lit,
    output logic                           span_valid,
    input  logic                           span_stall,
    output logic [8:0]                     span_x,
    output logic [5:0]                     span_y,
    output logic [8:0]                     span_length,
    output logic                           last_span,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [8:0]                     cfg_data
);

    mbse_pkg::cfg_t        cfg_reg, cfg_next;
    logic                  cfg_wr;
    logic                  queue_full;
    logic                  queue_nonempty;
    logic                  queue_push;
    logic                  queue_pop;
    mbse_pkg::span_entry_t push_entry;
    mbse_pkg::span_entry_t queue_head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file: decode the index, drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                mbse_pkg::CFG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data;
                mbse_pkg::CFG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data[6:0];
                mbse_pkg::CFG_DISPLAY_WIDTH:  cfg_next.display_width  = cfg_data;
                mbse_pkg::CFG_DISPLAY_HEIGHT: cfg_next.display_height = cfg_data[6:0];
                mbse_pkg::CFG_PANEL_WIDTH:    cfg_next.panel_width    = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= mbse_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= mbse_pkg::RST_FRAME_HEIGHT;
            cfg_reg.display_width  <= mbse_pkg::RST_DISPLAY_WIDTH;
            cfg_reg.display_height <= mbse_pkg::RST_DISPLAY_HEIGHT;
            cfg_reg.panel_width    <= mbse_pkg::RST_PANEL_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: track position, close runs, place spans
    mbse_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cfg_wr      (cfg_wr),
        .pixel_valid (pixel_valid),
        .pixel_lit   (pixel_lit),
        .pixel_stall (pixel_stall),
        .queue_full  (queue_full),
        .push        (queue_push),
        .push_entry  (push_entry)
    );

    // hold closed spans while the back replicates tiles
    mbse_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (push_entry),
        .pop       (queue_pop),
        .pop_data  (queue_head),
        .full      (queue_full),
        .nonempty  (queue_nonempty)
    );

    // back: emit each span, once or once per tile
    mbse_back
    #(
        .MAX_TILES (MAX_TILES)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .queue_nonempty (queue_nonempty),
        .queue_head     (queue_head),
        .queue_pop      (queue_pop),
        .span_valid     (span_valid),
        .span_stall     (span_stall),
        .span_x         (span_x),
        .span_y         (span_y),
        .span_length    (span_length),
        .last_span      (last_span)
    );

endmodule

// File: sv/mbse_front.sv
`timescale 1ns / 1ps

module mbse_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbse_pkg::cfg_t       cfg,
    input  logic                 cfg_wr,
    input  logic                 pixel_valid,
    input  logic                 pixel_lit,
    output logic                 pixel_stall,
    input  logic                 queue_full,
    output logic                 push,
    output mbse_pkg::span_entry_t push_entry
);

    logic [7:0] column_reg, column_next;
    logic [5:0] row_reg, row_next;
    logic [7:0] run_begin_reg, run_begin_next;
    logic       run_open_reg, run_open_next;
    logic [7:0] seg_start_reg, seg_start_next;
    logic [7:0] seg_off_reg, seg_off_next;
    logic       sync_busy_reg, sync_busy_next;
    logic [7:0] scan_reg, scan_next;

    logic [8:0] fw_eff;
    logic [6:0] fh_eff;
    logic [8:0] pw;
    logic [8:0] dw;
    logic [6:0] dh;
    logic       segmented;
    logic       tile_mode;
    logic       accept;
    logic [8:0] col_inc;
    logic       row_end;
    logic [9:0] seg_end_raw;
    logic [8:0] seg_end;
    logic [8:0] seg_prev_start;
    logic [8:0] seg_prev_end;
    logic       boundary;
    logic       closing;
    logic [7:0] run_end;
    logic [7:0] run_first;
    logic       use_prev;
    logic [8:0] ss_re;
    logic [8:0] se_re;
    logic [8:0] x_seg;
    logic [8:0] x_tile;
    logic [8:0] x_ctr;
    logic [8:0] hoff;
    logic [6:0] voff;
    logic       seg_wrap;
    logic [6:0] row_inc;

    assign pw = cfg.panel_width;
    assign dw = cfg.display_width;
    assign dh = cfg.display_height;

    always_comb
    begin
        if (cfg.frame_width == 9'd0)
        begin
            fw_eff = 9'd1;
        end
        else if (cfg.frame_width > mbse_pkg::MAX_FRAME_WIDTH)
        begin
            fw_eff = mbse_pkg::MAX_FRAME_WIDTH;
        end
        else
        begin
            fw_eff = cfg.frame_width;
        end
        if (cfg.frame_height == 7'd0)
        begin
            fh_eff = 7'd1;
        end
        else if (cfg.frame_height > mbse_pkg::MAX_FRAME_HEIGHT)
        begin
            fh_eff = mbse_pkg::MAX_FRAME_HEIGHT;
        end
        else
        begin
            fh_eff = cfg.frame_height;
        end
    end

    assign segmented = (pw != 9'd0) && (fw_eff > pw);
    assign tile_mode = (pw != 9'd0) && !segmented;

    assign pixel_stall = sync_busy_reg || queue_full || cfg_wr;
    assign accept      = pixel_valid && !pixel_stall;

    assign col_inc = {1'b0, column_reg} + 9'd1;
    assign row_end = col_inc >= fw_eff;

    // current segment end, clipped to the frame
    assign seg_end_raw = {2'b00, seg_start_reg} + {1'b0, pw};
    assign seg_end     = (seg_end_raw > {1'b0, fw_eff}) ? fw_eff : seg_end_raw[8:0];
    // previous segment, needed when an unlit pixel at a segment start closes a run
    assign seg_prev_start = {1'b0, seg_start_reg} - pw;
    assign seg_prev_end   = ({1'b0, seg_start_reg} > fw_eff) ? fw_eff
                                                             : {1'b0, seg_start_reg};

    assign boundary  = segmented ? (col_inc >= seg_end) : row_end;
    assign closing   = pixel_lit ? boundary : run_open_reg;
    assign run_end   = pixel_lit ? column_reg : (column_reg - 8'd1);
    assign run_first = run_open_reg ? run_begin_reg : column_reg;

    assign use_prev = !pixel_lit && (seg_off_reg == 8'd0);
    assign ss_re    = use_prev ? seg_prev_start : {1'b0, seg_start_reg};
    assign se_re    = use_prev ? seg_prev_end : seg_end;

    // mirror within the segment
    assign x_seg  = se_re + ss_re - 9'd1 - {1'b0, run_end};
    // mirror within the frame, inset to the middle of a tile
    assign x_tile = ((pw - fw_eff) >> 1) + (fw_eff - 9'd1 - {1'b0, run_end});
    assign hoff   = (dw > fw_eff) ? ((dw - fw_eff) >> 1) : 9'd0;
    assign x_ctr  = hoff + {1'b0, run_first};
    assign voff   = (dh > fh_eff) ? ((dh - fh_eff) >> 1) : 7'd0;

    always_comb
    begin
        if (pw == 9'd0)
        begin
            push_entry.x = x_ctr;
        end
        else if (segmented)
        begin
            push_entry.x = x_seg;
        end
        else
        begin
            push_entry.x = x_tile;
        end
        push_entry.y    = voff[5:0] + row_reg;
        push_entry.len  = {1'b0, run_end} - {1'b0, run_first} + 9'd1;
        push_entry.tile = tile_mode;
    end

    // tile mode with no display width yields nothing
    assign push = accept && closing && !(tile_mode && (dw == 9'd0));

    assign seg_wrap = ({1'b0, seg_off_reg} + 9'd1) == pw;
    assign row_inc  = {1'b0, row_reg} + 7'd1;

    always_comb
    begin
        column_next    = column_reg;
        row_next       = row_reg;
        run_begin_next = run_begin_reg;
        run_open_next  = run_open_reg;
        seg_start_next = seg_start_reg;
        seg_off_next   = seg_off_reg;
        sync_busy_next = sync_busy_reg;
        scan_next      = scan_reg;
        if (cfg_wr)
        begin
            // rebuild the segment position for the new panel width
            sync_busy_next = 1'b1;
            scan_next      = 8'd0;
            seg_start_next = 8'd0;
            seg_off_next   = 8'd0;
        end
        else if (sync_busy_reg)
        begin
            if (scan_reg == column_reg)
            begin
                sync_busy_next = 1'b0;
            end
            else
            begin
                scan_next = scan_reg + 8'd1;
                if (seg_wrap)
                begin
                    seg_start_next = seg_start_reg + pw[7:0];
                    seg_off_next   = 8'd0;
                end
                else
                begin
                    seg_off_next = seg_off_reg + 8'd1;
                end
            end
        end
        else if (accept)
        begin
            if (pixel_lit && !run_open_reg)
            begin
                run_begin_next = column_reg;
            end
            run_open_next = !row_end && pixel_lit && !boundary;
            if (row_end)
            begin
                column_next    = 8'd0;
                row_next       = (row_inc >= fh_eff) ? 6'd0 : row_inc[5:0];
                seg_start_next = 8'd0;
                seg_off_next   = 8'd0;
            end
            else
            begin
                column_next = col_inc[7:0];
                if (seg_wrap)
                begin
                    seg_start_next = seg_start_reg + pw[7:0];
                    seg_off_next   = 8'd0;
                end
                else
                begin
                    seg_off_next = seg_off_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= 8'd0;
            row_reg       <= 6'd0;
            run_begin_reg <= 8'd0;
            run_open_reg  <= 1'b0;
            seg_start_reg <= 8'd0;
            seg_off_reg   <= 8'd0;
            sync_busy_reg <= 1'b0;
            scan_reg      <= 8'd0;
        end
        else
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            run_begin_reg <= run_begin_next;
            run_open_reg  <= run_open_next;
            seg_start_reg <= seg_start_next;
            seg_off_reg   <= seg_off_next;
            sync_busy_reg <= sync_busy_next;
            scan_reg      <= scan_next;
        end
    end

endmodule

// File: sv/mbse_fifo.sv
`timescale 1ns / 1ps

`include "mono_bitmap_span_extractor_macros.svh"

module mbse_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mbse_pkg::span_entry_t push_data,
    input  logic                  pop,
    output mbse_pkg::span_entry_t pop_data,
    output logic                  full,
    output logic                  nonempty
);

    localparam int DEPTH = mbse_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mbse_pkg::span_entry_t entries [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full     = count_reg == (AW+1)'(DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MBSE_ASSERT_IMP(a_no_overflow, push, !full)
    `MBSE_ASSERT_IMP(a_no_underflow, pop, nonempty)

endmodule

// File: sv/mbse_back.sv
`timescale 1ns / 1ps

`include "mono_bitmap_span_extractor_macros.svh"

module mbse_back
#(
    parameter int MAX_TILES = mbse_pkg::MAX_TILES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mbse_pkg::cfg_t        cfg,
    input  logic                  queue_nonempty,
    input  mbse_pkg::span_entry_t queue_head,
    output logic                  queue_pop,
    output logic                  span_valid,
    input  logic                  span_stall,
    output logic [8:0]            span_x,
    output logic [5:0]            span_y,
    output logic [8:0]            span_length,
    output logic                  last_span
);

    localparam int KW   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int PS_W = 9 + KW;

    logic                  cur_valid_reg;
    mbse_pkg::span_entry_t cur_reg;
    logic [PS_W-1:0]       ps_reg;
    logic [KW-1:0]         k_reg;

    logic [PS_W-1:0] ps_sum;
    logic            is_last;
    logic            out_fire;

    assign ps_sum  = ps_reg + PS_W'(cfg.panel_width);
    // last if plain, at the tile cap, or if the next origin is off display
    assign is_last = !cur_reg.tile || (k_reg == KW'(MAX_TILES - 1))
                     || (ps_sum >= PS_W'(cfg.display_width));

    assign span_valid  = cur_valid_reg;
    assign span_x      = cur_reg.x + ps_reg[8:0];
    assign span_y      = cur_reg.y;
    assign span_length = cur_reg.len;
    assign last_span   = is_last;

    assign out_fire  = cur_valid_reg && !span_stall;
    assign queue_pop = queue_nonempty && (!cur_valid_reg || (out_fire && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ps_reg        <= '0;
            k_reg         <= '0;
        end
        else if (queue_pop)
        begin
            cur_valid_reg <= 1'b1;
            ps_reg        <= '0;
            k_reg         <= '0;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else
            begin
                ps_reg <= ps_sum;
                k_reg  <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            cur_reg <= queue_head;
        end
    end

    `MBSE_ASSERT_NEXT(a_tile_advance, out_fire && !is_last, span_valid && (k_reg == KW'($past(k_reg) + 1'b1)))
    `MBSE_ASSERT_IMP(a_plain_single, span_valid && !cur_reg.tile, (k_reg == '0) && (ps_reg == '0))

endmodule

// File: tb/mono_bitmap_span_extractor_test.sv
`timescale 1ns / 1ps

module mono_bitmap_span_extractor_test;

    localparam int TILES        = mbse_pkg::MAX_TILES_DEFAULT;
    localparam int RANDOM_ITEMS = 440;
    // Drop all idling once this close to the end of the random part.
    localparam int CALM_ITEMS   = 60;
    // Margin for the queue, the output register and the tile drain; long enough
    // for a pixel that closes nothing to leave the front before a register write.
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 160;
    localparam int PLAN_LEN     = 30;

    typedef struct packed {
        logic [8:0] x;
        logic [5:0] y;
        logic [8:0] len;
        logic       last;
    } span_t;

    // STEP_PIXEL:   p0 = lit, result left to the span predictor
    // STEP_CHECKED: p0 = lit, p1/p2/p3 = x/y/length of the single span it closes
    // STEP_SETUP:   p0..p4 = frame width, frame height, display width,
    //               display height, panel width
    typedef enum logic [1:0] {STEP_PIXEL, STEP_CHECKED, STEP_SETUP} step_kind_t;

    typedef struct packed {
        step_kind_t kind;
        logic [8:0] p0;
        logic [8:0] p1;
        logic [8:0] p2;
        logic [8:0] p3;
        logic [8:0] p4;
    } plan_step_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           pixel_valid = 1'b0;
    logic                           pixel_lit   = 1'b0;
    logic                           span_stall  = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic [mbse_pkg::CFG_IDX_W-1:0] cfg_index   = mbse_pkg::CFG_FRAME_WIDTH;
    logic [8:0]                     cfg_data    = 9'd0;

    logic       pixel_stall;
    logic       span_valid;
    logic [8:0] span_x;
    logic [5:0] span_y;
    logic [8:0] span_length;
    logic       last_span;
    logic       cfg_ready;

    // Shadow copy of the registers, as the block should hold them.
    logic [8:0] fw_reg = mbse_pkg::RST_FRAME_WIDTH;
    logic [6:0] fh_reg = mbse_pkg::RST_FRAME_HEIGHT;
    logic [8:0] dw_reg = mbse_pkg::RST_DISPLAY_WIDTH;
    logic [6:0] dh_reg = mbse_pkg::RST_DISPLAY_HEIGHT;
    logic [8:0] pw_reg = mbse_pkg::RST_PANEL_WIDTH;

    // Shadow raster position and open run.
    int unsigned col_q       = 0;
    int unsigned row_q       = 0;
    int unsigned run_start_q = 0;
    bit          run_live_q  = 1'b0;

    span_t spans_due [$];

    bit failed       = 1'b0;
    bit calm         = 1'b0;
    int hold_asks    = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int burst_left   = 0;
    int quiet_left   = 0;
    int random_sent  = 0;

    // Directed walk. Starts on the reset settings, then visits the clamped
    // widths and heights, a frame larger than its display, tile mode with
    // the column wrapping past 511, tile mode with no tiles at all, and a
    // segmented row whose last segment is short.
    plan_step_t plan [PLAN_LEN] = '{
        // reset settings: lit at column 0, closed by the unlit pixel after it
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_CHECKED, 9'd0,   9'd0,   9'd0,   9'd1,   9'd0},
        // width zero acts as one: every pixel ends its row; height zero acts
        // as one; centring offsets are (511 - 1) / 2 and (127 - 1) / 2
        '{STEP_SETUP,   9'd0,   9'd0,   9'd511, 9'd127, 9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_CHECKED, 9'd1,   9'd255, 9'd63,  9'd1,   9'd0},
        '{STEP_PIXEL,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        // oversized width and height clamp to 256 x 64, wider and taller
        // than the display, so both offsets are zero
        '{STEP_SETUP,   9'd511, 9'd100, 9'd8,   9'd1,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_CHECKED, 9'd0,   9'd0,   9'd0,   9'd2,   9'd0},
        // tile mode, four tiles of 170 on a 511 display: the last one wraps
        '{STEP_SETUP,   9'd8,   9'd2,   9'd511, 9'd64,  9'd170},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        // tile mode on a display of width zero: spans close, nothing leaves
        '{STEP_SETUP,   9'd8,   9'd2,   9'd0,   9'd64,  9'd16},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        // segments of 8 in a row of 12: a full segment, then a short one
        '{STEP_SETUP,   9'd12,  9'd64,  9'd64,  9'd64,  9'd8},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0},
        '{STEP_PIXEL,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0}
    };

    mono_bitmap_span_extractor i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_lit   (pixel_lit),
        .span_valid  (span_valid),
        .span_stall  (span_stall),
        .span_x      (span_x),
        .span_y      (span_y),
        .span_length (span_length),
        .last_span   (last_span),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    // Span predictor: advance the shadow position by one pixel and return
    // the spans that pixel closes, in the order the block sends them.
    // All position arithmetic runs at 32 bits and is cut to the port widths,
    // so a mid-row register change wraps the same way the block does.
    task automatic extract_spans(input bit lit, output span_t found [TILES],
                                 output int count);
        int unsigned fw, fh, pw, c, ss, se, lw, rb, re, voff, hoff, y, len;
        int unsigned mirrored, inset, ps, xv;
        bit seg, boundary, closing;
        fw = (fw_reg == 0) ? 1 : (fw_reg > 256) ? 256 : fw_reg;
        fh = (fh_reg == 0) ? 1 : (fh_reg > 64) ? 64 : fh_reg;
        pw = pw_reg;
        seg = (pw != 0) && (fw > pw);
        c = col_q;
        count = 0;
        closing = 1'b0;
        rb = 0;
        re = 0;
        for (int k = 0; k < TILES; k++)
            found[k] = '0;

        // A run also closes at the last column of its segment.
        if (seg)
        begin
            ss = c - (c % pw);
            se = ss + pw;
            if (se > fw)
                se = fw;
            boundary = (c + 1) >= se;
        end
        else
            boundary = (c + 1) >= fw;

        if (lit)
        begin
            if (!run_live_q)
            begin
                run_start_q = c;
                run_live_q  = 1'b1;
            end
            if (boundary)
            begin
                rb = run_start_q;
                re = c;
                run_live_q = 1'b0;
                closing = 1'b1;
            end
        end
        else if (run_live_q)
        begin
            rb = run_start_q;
            re = (c - 1) & 32'hFF;
            run_live_q = 1'b0;
            closing = 1'b1;
        end

        if (closing)
        begin
            voff = (dh_reg > fh) ? (dh_reg - fh) / 2 : 0;
            y    = voff + row_q;
            len  = re - rb + 1;
            if (pw == 0)
            begin
                hoff = (dw_reg > fw) ? (dw_reg - fw) / 2 : 0;
                xv = hoff + rb;
                found[0] = '{x: xv[8:0], y: y[5:0], len: len[8:0], last: 1'b0};
                count = 1;
            end
            else if (!seg)
            begin
                // Mirror inside the frame, centre inside each tile.
                mirrored = (fw - 1) - re;
                inset    = (pw - fw) / 2;
                for (ps = 0; ps < dw_reg && count < TILES; ps += pw)
                begin
                    xv = ps + inset + mirrored;
                    found[count] = '{x: xv[8:0], y: y[5:0], len: len[8:0], last: 1'b0};
                    count++;
                end
            end
            else
            begin
                // Mirror inside the segment that holds the run's end.
                ss = re - (re % pw);
                se = ss + pw;
                if (se > fw)
                    se = fw;
                lw = se - ss;
                xv = ss + (lw - 1) - (re - ss);
                found[0] = '{x: xv[8:0], y: y[5:0], len: len[8:0], last: 1'b0};
                count = 1;
            end
            if (count > 0)
                found[count - 1].last = 1'b1;
        end

        if ((c + 1) >= fw)
        begin
            col_q = 0;
            row_q = ((row_q + 1) >= fh) ? 0 : row_q + 1;
            run_live_q = 1'b0;
        end
        else
            col_q = (c + 1) & 32'hFF;
    endtask

    // Offer one pixel request, now and then after a gap, and hold it until
    // taken. Queue the spans it closes: the typed-in one when given, else
    // the predicted ones.
    task automatic push_pixel(input bit lit, input bit given, input span_t given_span);
        span_t found [TILES];
        int    count;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_lit   <= lit;
        do
            @(posedge clk);
        while (pixel_stall);
        extract_spans(lit, found, count);
        if (given)
            spans_due.push_back(given_span);
        else
            for (int k = 0; k < count; k++)
                spans_due.push_back(found[k]);
    endtask

    // Drop the pixel request and wait until every expected span is out,
    // then let the pipeline run dry of pixels that close nothing.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all five registers back to back; only call while idle.
    task automatic set_config(input logic [8:0] fw, input logic [8:0] fh,
                              input logic [8:0] dw, input logic [8:0] dh,
                              input logic [8:0] pw);
        logic [8:0]                     vals [5];
        logic [mbse_pkg::CFG_IDX_W-1:0] idxs [5];
        vals = '{fw, fh, dw, dh, pw};
        idxs = '{mbse_pkg::CFG_FRAME_WIDTH, mbse_pkg::CFG_FRAME_HEIGHT,
                 mbse_pkg::CFG_DISPLAY_WIDTH, mbse_pkg::CFG_DISPLAY_HEIGHT,
                 mbse_pkg::CFG_PANEL_WIDTH};
        for (int k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idxs[k])
                mbse_pkg::CFG_FRAME_WIDTH:    fw_reg = vals[k];
                mbse_pkg::CFG_FRAME_HEIGHT:   fh_reg = vals[k][6:0];
                mbse_pkg::CFG_DISPLAY_WIDTH:  dw_reg = vals[k];
                mbse_pkg::CFG_DISPLAY_HEIGHT: dh_reg = vals[k][6:0];
                mbse_pkg::CFG_PANEL_WIDTH:    pw_reg = vals[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] want,
                                   input logic [8:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        failed = 1'b1;
    endtask

    // Span receiver. Serve a requested long hold first; otherwise stall in
    // random bursts separated by short or long quiet stretches, and stop
    // stalling altogether near the end of the run.
    always @(posedge clk)
    begin
        if (!rst_n)
            span_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            span_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            span_stall  <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_asks;
        end
        else if (calm)
            span_stall <= 1'b0;
        else if (burst_left != 0)
        begin
            span_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end
        else if (quiet_left != 0)
        begin
            span_stall <= 1'b0;
            quiet_left <= quiet_left - 1;
        end
        else
        begin
            span_stall <= 1'b1;
            burst_left <= $urandom_range(0, 12);
            quiet_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 12);
        end
    end

    // Compare every accepted span request with the oldest expectation.
    always @(posedge clk)
    begin : span_check
        span_t want;
        if (rst_n && span_valid && !span_stall)
        begin
            if (spans_due.size() == 0)
            begin
                $display("%0t: span with nothing expected, x=%0d y=%0d length=%0d last=%0b",
                         $time, span_x, span_y, span_length, last_span);
                failed = 1'b1;
            end
            else
            begin
                want = spans_due.pop_front();
                if (want.x !== span_x)
                    report_mismatch("span_x", want.x, span_x);
                if (want.y !== span_y)
                    report_mismatch("span_y", 9'(want.y), 9'(span_y));
                if (want.len !== span_length)
                    report_mismatch("span_length", want.len, span_length);
                if (want.last !== last_span)
                    report_mismatch("last_span", 9'(want.last), 9'(last_span));
            end
        end
    end

    initial
    begin
        #(2_000_000);
        $display("** mono_bitmap_span_extractor: FAILED **");
        $finish;
    end

    initial
    begin
        logic [8:0] fw, fh, dw, dh, pw;
        int         n, style, left, guard;
        bit         cur, lit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk; a setup row waits for the block to go idle first.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            case (plan[i].kind)
                STEP_SETUP:
                begin
                    settle();
                    set_config(plan[i].p0, plan[i].p1, plan[i].p2, plan[i].p3, plan[i].p4);
                end
                STEP_CHECKED:
                    push_pixel(plan[i].p0[0], 1'b1,
                               '{x: plan[i].p1, y: plan[i].p2[5:0], len: plan[i].p3,
                                 last: 1'b1});
                default:
                    push_pixel(plan[i].p0[0], 1'b0, '0);
            endcase
        end

        // Widest row, fully lit from column zero: one span of 256.
        while (col_q != 0)
            push_pixel(1'b0, 1'b0, '0);
        settle();
        set_config(9'd256, 9'd4, 9'd256, 9'd64, 9'd0);
        for (int k = 0; k < 256; k++)
            push_pixel(1'b1, 1'b0, '0);
        random_sent += 256;

        // Long receiver hold in four-tile mode: keep offering pixels that
        // close a span on every other pixel until the span queue fills and the
        // block stalls its pixel input.
        settle();
        set_config(9'd8, 9'd3, 9'd64, 9'd32, 9'd16);
        hold_asks <= hold_asks + 1;
        for (int k = 0; k < 40; k++)
            push_pixel(k[0] == 1'b0, 1'b0, '0);
        random_sent += 40;

        // Random phases: new settings, then a burst of pixels, mostly runs.
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            fh = 9'($urandom_range(1, 6));
            dh = 9'($urandom_range(0, 70));
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    fw = 9'(8 * $urandom_range(1, 4));
                    dw = 9'($urandom_range(0, 100));
                    pw = 9'd0;
                end
                3, 4, 5:
                begin
                    fw = 9'(8 * $urandom_range(1, 3));
                    pw = 9'(fw + $urandom_range(0, 24));
                    dw = ($urandom_range(0, 4) == 0) ? 9'd0 : 9'($urandom_range(1, 300));
                end
                6, 7, 8:
                begin
                    fw = 9'($urandom_range(9, 40));
                    pw = 9'($urandom_range(1, fw - 1));
                    dw = 9'($urandom_range(0, 100));
                end
                default:
                begin
                    // Register extremes and out-of-range values.
                    fw = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 9'd0 : 9'd256)
                                              : 9'($urandom_range(257, 511));
                    case ($urandom_range(0, 4))
                        0: pw = 9'd0;
                        1: pw = 9'd1;
                        2: pw = 9'd255;
                        3: pw = 9'd256;
                        default: pw = 9'd511;
                    endcase
                    dw = $urandom_range(0, 1) ? 9'd511 : 9'd0;
                    fh = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(64, 127));
                    dh = $urandom_range(0, 1) ? 9'd127 : 9'd0;
                end
            endcase
            set_config(fw, fh, dw, dh, pw);

            n     = $urandom_range(12, 40);
            style = $urandom_range(0, 4);
            cur   = 1'b0;
            left  = 0;
            for (int k = 0; k < n; k++)
            begin
                if (style == 0)
                    lit = 1'($urandom_range(0, 1));
                else if (style == 1)
                    lit = ($urandom_range(0, 15) != 0);
                else
                begin
                    if (left == 0)
                    begin
                        cur  = !cur;
                        left = cur ? $urandom_range(1, 12) : $urandom_range(1, 3);
                    end
                    lit = cur;
                    left--;
                end
                push_pixel(lit, 1'b0, '0);
                random_sent++;
                if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
                    calm <= 1'b1;
            end
        end

        // Drain, then keep watching for anything unexpected before the verdict.
        pixel_valid <= 1'b0;
        guard = 0;
        while (spans_due.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);

        if (!failed && spans_due.size() == 0)
            $display("** mono_bitmap_span_extractor: PASSED **");
        else
            $display("** mono_bitmap_span_extractor: FAILED **");
        $finish;
    end

endmodule
